// ===== rtl/core/surface_tension_face_stiffness_assert.svh =====
// Assertion macros for the face stiffness block and its checker.
`ifndef SURFACE_TENSION_FACE_STIFFNESS_ASSERT_SVH
`define SURFACE_TENSION_FACE_STIFFNESS_ASSERT_SVH

// Check a condition in the same cycle as its trigger.
`define STFS_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check a condition in the cycle after its trigger.
`define STFS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/stfs_pkg.sv =====
`timescale 1ns / 1ps
package stfs_pkg;

    localparam int RootW  = 33;
    localparam int UW     = 31;
    localparam int GlW    = 48;

    localparam logic [31:0] RampTimeReset = 32'h0001_0000;
    localparam logic [31:0] ScaleReset    = 32'h0001_0000;

    // Register indexes of the configuration port
    typedef enum logic [2:0] {
        CFG_SURFACE_TENSION = 3'd0,
        CFG_RAMP_TIME       = 3'd1,
        CFG_CURRENT_TIME    = 3'd2,
        CFG_DYNAMIC_MODE    = 3'd3,
        CFG_STIFFNESS_SCALE = 3'd4
    } cfg_idx_t;

    // Per-item flags that travel alongside the arithmetic
    typedef struct packed {
        logic       zero;
        logic       xy_neg;
        logic       fx_neg;
        logic       fy_neg;
        logic [2:0] first_dof;
        logic [2:0] second_dof;
    } side_t;

    typedef struct packed {
        logic [31:0] stiff_xx;
        logic [31:0] stiff_xy;
        logic [31:0] stiff_yy;
        logic [31:0] force_x;
        logic [31:0] force_y;
        logic [2:0]  first_dof;
        logic [2:0]  second_dof;
        logic        zero_length;
    } res_t;

    // Apply sign to a magnitude and clamp to the signed 32-bit range
    function automatic logic [31:0] sat_signed(input logic [64:0] mag, input logic neg);
        logic [31:0] r;
        if (neg) begin
            if (mag >= 65'h0_8000_0000) r = 32'h8000_0000;
            else                        r = 32'd0 - mag[31:0];
        end else begin
            if (mag > 65'h0_7FFF_FFFF) r = 32'h7FFF_FFFF;
            else                       r = mag[31:0];
        end
        return r;
    endfunction

endpackage

// ===== rtl/core/surface_tension_face_stiffness.sv =====
`timescale 1ns / 1ps
// Surface-tension stiffness of one free face of a quad element.
// Input channel (in_valid/in_ready): one face per item, two end points in
// signed Q16.16 and the local node numbers of its two nodes.
// Output channel (out_valid/out_ready): one result per face, in order: the
// 2x2 stiffness block, the residual at the first node, the DOF base indices
// and a zero-length flag.
// Config channel (cfg_valid/cfg_ready/cfg_index/cfg_data): always ready.
// Throughput is one face per cycle unless the skid register or the ramp
// unit holds in_ready low. A face passes 3 front stages (difference,
// squares, sum), 33 square-root stages, 48 divider stages (length
// division, one quotient bit per stage), 7 multiply and saturate stages
// and the output register. A write to the tension, ramp time or current
// time restarts the ramp unit, a serial divider that holds in_ready low.
// Reset loads the register defaults and empties the pipeline.
// When the receiver stalls, one more result lands in a skid register; after
// that the whole pipeline holds and in_ready drops.
module surface_tension_face_stiffness (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [31:0] first_x,
    input  logic signed [31:0] second_x,
    input  logic signed [31:0] first_y,
    input  logic signed [31:0] second_y,
    input  logic [1:0]         first_node,
    input  logic [1:0]         second_node,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] stiff_xx,
    output logic signed [31:0] stiff_xy,
    output logic signed [31:0] stiff_yy,
    output logic signed [31:0] force_x,
    output logic signed [31:0] force_y,
    output logic [2:0]         first_dof,
    output logic [2:0]         second_dof,
    output logic               zero_length,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_data
);

    logic [31:0]     tension_reg, ramp_reg, time_reg, scale_reg;
    logic            dyn_reg;
    logic            cfg_take, ramp_start, gamma_busy;
    logic [31:0]     gamma;
    logic            adv, in_take;
    logic            f_vld, s_vld, d_vld, b_vld;
    logic [65:0]     rad;
    logic [32:0]     f_ax, f_ay, s_ax, s_ay, len;
    stfs_pkg::side_t f_side, s_side, d_side;
    logic [30:0]     u, v;
    logic [47:0]     gl;
    stfs_pkg::res_t  b_res, out_reg, skid_reg;
    logic            out_vld_reg, skid_vld_reg;

    assign cfg_ready = 1'b1;
    assign cfg_take  = cfg_valid && cfg_ready;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tension_reg <= '0;
            ramp_reg    <= stfs_pkg::RampTimeReset;
            time_reg    <= '0;
            dyn_reg     <= 1'b0;
            scale_reg   <= stfs_pkg::ScaleReset;
        end else if (cfg_take) begin
            case (stfs_pkg::cfg_idx_t'(cfg_index))
                stfs_pkg::CFG_SURFACE_TENSION: tension_reg <= cfg_data;
                stfs_pkg::CFG_RAMP_TIME:       ramp_reg    <= cfg_data;
                stfs_pkg::CFG_CURRENT_TIME:    time_reg    <= cfg_data;
                stfs_pkg::CFG_DYNAMIC_MODE:    dyn_reg     <= cfg_data[0];
                stfs_pkg::CFG_STIFFNESS_SCALE: scale_reg   <= cfg_data;
                default:                       dyn_reg     <= dyn_reg;
            endcase
        end
    end

    assign ramp_start = cfg_take &&
        ((cfg_index == stfs_pkg::CFG_SURFACE_TENSION) ||
         (cfg_index == stfs_pkg::CFG_RAMP_TIME) ||
         (cfg_index == stfs_pkg::CFG_CURRENT_TIME));

    stfs_gamma u_gamma (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (ramp_start),
        .surface_tension (tension_reg),
        .ramp_time       (ramp_reg),
        .current_time    (time_reg),
        .gamma           (gamma),
        .busy            (gamma_busy)
    );

    // Pipeline advances unless the skid register is occupied
    assign adv      = !skid_vld_reg;
    assign in_ready = adv && !gamma_busy;
    assign in_take  = in_valid && in_ready;

    stfs_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .adv         (adv),
        .in_take     (in_take),
        .first_x     (first_x),
        .second_x    (second_x),
        .first_y     (first_y),
        .second_y    (second_y),
        .first_node  (first_node),
        .second_node (second_node),
        .out_vld     (f_vld),
        .rad         (rad),
        .ax          (f_ax),
        .ay          (f_ay),
        .side        (f_side)
    );

    stfs_sqrt u_sqrt (
        .clk     (clk),
        .rst_n   (rst_n),
        .adv     (adv),
        .in_vld  (f_vld),
        .rad     (rad),
        .ax      (f_ax),
        .ay      (f_ay),
        .side    (f_side),
        .out_vld (s_vld),
        .len     (len),
        .ax_o    (s_ax),
        .ay_o    (s_ay),
        .side_o  (s_side)
    );

    stfs_div u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .adv     (adv),
        .in_vld  (s_vld),
        .len     (len),
        .ax      (s_ax),
        .ay      (s_ay),
        .gamma   (gamma),
        .side    (s_side),
        .out_vld (d_vld),
        .u       (u),
        .v       (v),
        .gl      (gl),
        .side_o  (d_side)
    );

    stfs_back u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .adv             (adv),
        .in_vld          (d_vld),
        .u               (u),
        .v               (v),
        .gl              (gl),
        .side            (d_side),
        .gamma           (gamma),
        .dynamic_mode    (dyn_reg),
        .stiffness_scale (scale_reg),
        .out_vld         (b_vld),
        .res             (b_res)
    );

    // Output register with skid: park one item while the receiver stalls
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg  <= 1'b0;
            skid_vld_reg <= 1'b0;
        end else if (!out_vld_reg || out_ready) begin
            out_vld_reg  <= skid_vld_reg || (b_vld && adv);
            skid_vld_reg <= 1'b0;
        end else if (b_vld && adv) begin
            skid_vld_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_vld_reg || out_ready)
        begin
            out_reg <= skid_vld_reg ? skid_reg : b_res;
        end else if (b_vld && adv) begin
            skid_reg <= b_res;
        end
    end

    assign out_valid   = out_vld_reg;
    assign stiff_xx    = out_reg.stiff_xx;
    assign stiff_xy    = out_reg.stiff_xy;
    assign stiff_yy    = out_reg.stiff_yy;
    assign force_x     = out_reg.force_x;
    assign force_y     = out_reg.force_y;
    assign first_dof   = out_reg.first_dof;
    assign second_dof  = out_reg.second_dof;
    assign zero_length = out_reg.zero_length;

endmodule

// ===== rtl/core/stfs_gamma.sv =====
`timescale 1ns / 1ps
module stfs_gamma (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] surface_tension,
    input  logic [31:0] ramp_time,
    input  logic [31:0] current_time,
    output logic [31:0] gamma,
    output logic        busy
);

    typedef enum logic [2:0] {
        G_IDLE = 3'b001,
        G_LOAD = 3'b010,
        G_DIV  = 3'b100
    } gstate_t;

    gstate_t     state_reg, state_next;
    logic [63:0] rem_reg, rem_next;
    logic [63:0] div_reg, div_next;
    logic [31:0] quo_reg, quo_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic [31:0] gamma_reg, gamma_next;
    logic        ge;

    assign ge = rem_reg >= div_reg;

    // Ramp the tension: restoring division, one quotient bit per cycle
    always_comb
    begin
        state_next = state_reg;
        rem_next   = rem_reg;
        div_next   = div_reg;
        quo_next   = quo_reg;
        cnt_next   = cnt_reg;
        gamma_next = gamma_reg;
        case (state_reg)
            G_IDLE:
            begin
                state_next = G_IDLE;
            end
            G_LOAD:
            begin
                if (current_time >= ramp_time)
                begin
                    gamma_next = surface_tension;
                    state_next = G_IDLE;
                end else begin
                    rem_next   = current_time * surface_tension;
                    div_next   = {1'b0, ramp_time, 31'd0};
                    quo_next   = '0;
                    cnt_next   = 5'd31;
                    state_next = G_DIV;
                end
            end
            G_DIV:
            begin
                if (ge) rem_next = rem_reg - div_reg;
                div_next = {1'b0, div_reg[63:1]};
                quo_next = {quo_reg[30:0], ge};
                cnt_next = cnt_reg - 5'd1;
                if (cnt_reg == 5'd0)
                begin
                    gamma_next = {quo_reg[30:0], ge};
                    state_next = G_IDLE;
                end
            end
            default:
            begin
                state_next = G_IDLE;
            end
        endcase
        if (start) state_next = G_LOAD;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= G_IDLE;
            gamma_reg <= '0;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            gamma_reg <= gamma_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        div_reg <= div_next;
        quo_reg <= quo_next;
    end

    assign gamma = gamma_reg;
    assign busy  = state_reg != G_IDLE;

endmodule

// ===== rtl/core/stfs_front.sv =====
`timescale 1ns / 1ps
module stfs_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                adv,
    input  logic                in_take,
    input  logic signed [31:0]  first_x,
    input  logic signed [31:0]  second_x,
    input  logic signed [31:0]  first_y,
    input  logic signed [31:0]  second_y,
    input  logic [1:0]          first_node,
    input  logic [1:0]          second_node,
    output logic                out_vld,
    output logic [65:0]         rad,
    output logic [32:0]         ax,
    output logic [32:0]         ay,
    output stfs_pkg::side_t     side
);

    logic [32:0]     dx, dy, ax_n, ay_n;
    logic            dx_pos, dy_pos, dx_neg, dy_neg;
    stfs_pkg::side_t side_n;
    logic [2:0]      vld_reg;
    logic [32:0]     ax1_reg, ay1_reg, ax2_reg, ay2_reg, ax3_reg, ay3_reg;
    logic [65:0]     sx2_reg, sy2_reg, rad3_reg;
    stfs_pkg::side_t side1_reg, side2_reg, side3_reg;

    // Form the edge vector and its magnitudes
    assign dx     = {first_x[31], first_x} - {second_x[31], second_x};
    assign dy     = {first_y[31], first_y} - {second_y[31], second_y};
    assign dx_neg = dx[32];
    assign dy_neg = dy[32];
    assign dx_pos = !dx[32] && (dx != '0);
    assign dy_pos = !dy[32] && (dy != '0);
    assign ax_n   = dx_neg ? (33'd0 - dx) : dx;
    assign ay_n   = dy_neg ? (33'd0 - dy) : dy;

    always_comb
    begin
        side_n.zero       = (dx == '0) && (dy == '0);
        side_n.xy_neg     = (dx_pos && dy_pos) || (dx_neg && dy_neg);
        side_n.fx_neg     = dx_pos;
        side_n.fy_neg     = dy_pos;
        side_n.first_dof  = {first_node, 1'b0};
        side_n.second_dof = {second_node, 1'b0};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= {vld_reg[1:0], in_take};
        end
    end

    // Square, then sum the squares
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ax1_reg   <= ax_n;
            ay1_reg   <= ay_n;
            side1_reg <= side_n;
            sx2_reg   <= ax1_reg * ax1_reg;
            sy2_reg   <= ay1_reg * ay1_reg;
            ax2_reg   <= ax1_reg;
            ay2_reg   <= ay1_reg;
            side2_reg <= side1_reg;
            rad3_reg  <= sx2_reg + sy2_reg;
            ax3_reg   <= ax2_reg;
            ay3_reg   <= ay2_reg;
            side3_reg <= side2_reg;
        end
    end

    assign out_vld = vld_reg[2];
    assign rad     = rad3_reg;
    assign ax      = ax3_reg;
    assign ay      = ay3_reg;
    assign side    = side3_reg;

endmodule

// ===== rtl/core/stfs_sqrt.sv =====
`timescale 1ns / 1ps
module stfs_sqrt (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                adv,
    input  logic                in_vld,
    input  logic [65:0]         rad,
    input  logic [32:0]         ax,
    input  logic [32:0]         ay,
    input  stfs_pkg::side_t     side,
    output logic                out_vld,
    output logic [32:0]         len,
    output logic [32:0]         ax_o,
    output logic [32:0]         ay_o,
    output stfs_pkg::side_t     side_o
);

    localparam int N = stfs_pkg::RootW;

    logic [65:0]     rem_in   [N];
    logic [32:0]     root_in  [N];
    logic [32:0]     ax_in    [N];
    logic [32:0]     ay_in    [N];
    stfs_pkg::side_t side_in  [N];
    logic            vld_in   [N];
    logic [65:0]     rem_reg  [N];
    logic [32:0]     root_reg [N];
    logic [32:0]     ax_reg   [N];
    logic [32:0]     ay_reg   [N];
    stfs_pkg::side_t side_reg [N];
    logic            vld_reg  [N];

    // One root bit per stage, most significant first
    for (genvar s = 0; s < N; s++)
    begin : g_stage
        localparam int B = N - 1 - s;
        logic [66:0] trial, diff;
        logic        ge;

        if (s == 0)
        begin : g_first
            assign rem_in[s]  = rad;
            assign root_in[s] = '0;
            assign ax_in[s]   = ax;
            assign ay_in[s]   = ay;
            assign side_in[s] = side;
            assign vld_in[s]  = in_vld;
        end else begin : g_next
            assign rem_in[s]  = rem_reg[s-1];
            assign root_in[s] = root_reg[s-1];
            assign ax_in[s]   = ax_reg[s-1];
            assign ay_in[s]   = ay_reg[s-1];
            assign side_in[s] = side_reg[s-1];
            assign vld_in[s]  = vld_reg[s-1];
        end

        assign trial = ({34'd0, root_in[s]} << (B + 1)) + (67'd1 << (2 * B));
        assign diff  = {1'b0, rem_in[s]} - trial;
        assign ge    = {1'b0, rem_in[s]} >= trial;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[s] <= 1'b0;
            end else if (adv) begin
                vld_reg[s] <= vld_in[s];
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                rem_reg[s]  <= ge ? diff[65:0] : rem_in[s];
                root_reg[s] <= root_in[s] | (ge ? (33'd1 << B) : 33'd0);
                ax_reg[s]   <= ax_in[s];
                ay_reg[s]   <= ay_in[s];
                side_reg[s] <= side_in[s];
            end
        end
    end

    assign out_vld = vld_reg[N-1];
    assign len     = root_reg[N-1];
    assign ax_o    = ax_reg[N-1];
    assign ay_o    = ay_reg[N-1];
    assign side_o  = side_reg[N-1];

endmodule

// ===== rtl/core/stfs_div.sv =====
`timescale 1ns / 1ps
module stfs_div (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                adv,
    input  logic                in_vld,
    input  logic [32:0]         len,
    input  logic [32:0]         ax,
    input  logic [32:0]         ay,
    input  logic [31:0]         gamma,
    input  stfs_pkg::side_t     side,
    output logic                out_vld,
    output logic [30:0]         u,
    output logic [30:0]         v,
    output logic [47:0]         gl,
    output stfs_pkg::side_t     side_o
);

    localparam int N = stfs_pkg::GlW;

    logic [63:0]     ru_in [N], rv_in [N], rg_in [N];
    logic [30:0]     qu_in [N], qv_in [N];
    logic [47:0]     qg_in [N];
    logic [32:0]     len_in [N];
    stfs_pkg::side_t side_in [N];
    logic            vld_in [N];
    logic [63:0]     ru_reg [N], rv_reg [N], rg_reg [N];
    logic [30:0]     qu_reg [N], qv_reg [N];
    logic [47:0]     qg_reg [N];
    logic [32:0]     len_reg [N];
    stfs_pkg::side_t side_reg [N];
    logic            vld_reg [N];

    // Three restoring divisions by the length, one quotient bit per stage
    for (genvar s = 0; s < N; s++)
    begin : g_stage
        localparam int B = N - 1 - s;
        logic [80:0] dsh, dg;
        logic        geg;
        logic [63:0] ru_n, rv_n;
        logic [30:0] qu_n, qv_n;

        if (s == 0)
        begin : g_first
            assign ru_in[s]   = {1'b0, ax, 30'd0};
            assign rv_in[s]   = {1'b0, ay, 30'd0};
            assign rg_in[s]   = {16'd0, gamma, 16'd0};
            assign qu_in[s]   = '0;
            assign qv_in[s]   = '0;
            assign qg_in[s]   = '0;
            assign len_in[s]  = len;
            assign side_in[s] = side;
            assign vld_in[s]  = in_vld;
        end else begin : g_next
            assign ru_in[s]   = ru_reg[s-1];
            assign rv_in[s]   = rv_reg[s-1];
            assign rg_in[s]   = rg_reg[s-1];
            assign qu_in[s]   = qu_reg[s-1];
            assign qv_in[s]   = qv_reg[s-1];
            assign qg_in[s]   = qg_reg[s-1];
            assign len_in[s]  = len_reg[s-1];
            assign side_in[s] = side_reg[s-1];
            assign vld_in[s]  = vld_reg[s-1];
        end

        assign dsh = {48'd0, len_in[s]} << B;
        assign geg = {17'd0, rg_in[s]} >= dsh;
        assign dg  = {17'd0, rg_in[s]} - dsh;

        // Direction quotients never exceed one, so their upper bits stay clear
        if (B < stfs_pkg::UW)
        begin : g_uv
            logic [80:0] du, dv;
            logic        geu, gev;
            assign geu  = {17'd0, ru_in[s]} >= dsh;
            assign gev  = {17'd0, rv_in[s]} >= dsh;
            assign du   = {17'd0, ru_in[s]} - dsh;
            assign dv   = {17'd0, rv_in[s]} - dsh;
            assign ru_n = geu ? du[63:0] : ru_in[s];
            assign rv_n = gev ? dv[63:0] : rv_in[s];
            assign qu_n = qu_in[s] | (geu ? (31'd1 << B) : 31'd0);
            assign qv_n = qv_in[s] | (gev ? (31'd1 << B) : 31'd0);
        end else begin : g_pass
            assign ru_n = ru_in[s];
            assign rv_n = rv_in[s];
            assign qu_n = qu_in[s];
            assign qv_n = qv_in[s];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[s] <= 1'b0;
            end else if (adv) begin
                vld_reg[s] <= vld_in[s];
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                ru_reg[s]   <= ru_n;
                rv_reg[s]   <= rv_n;
                rg_reg[s]   <= geg ? dg[63:0] : rg_in[s];
                qu_reg[s]   <= qu_n;
                qv_reg[s]   <= qv_n;
                qg_reg[s]   <= qg_in[s] | (geg ? (48'd1 << B) : 48'd0);
                len_reg[s]  <= len_in[s];
                side_reg[s] <= side_in[s];
            end
        end
    end

    assign out_vld = vld_reg[N-1];
    assign u       = qu_reg[N-1];
    assign v       = qv_reg[N-1];
    assign gl      = qg_reg[N-1];
    assign side_o  = side_reg[N-1];

endmodule

// ===== rtl/core/stfs_back.sv =====
`timescale 1ns / 1ps
module stfs_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                adv,
    input  logic                in_vld,
    input  logic [30:0]         u,
    input  logic [30:0]         v,
    input  logic [47:0]         gl,
    input  stfs_pkg::side_t     side,
    input  logic [31:0]         gamma,
    input  logic                dynamic_mode,
    input  logic [31:0]         stiffness_scale,
    output logic                out_vld,
    output stfs_pkg::res_t      res
);

    logic [6:0]      vld_reg;
    logic [61:0]     uu1_reg, vv1_reg, uv1_reg;
    logic [62:0]     fpx1_reg, fpy1_reg;
    logic [47:0]     gl1_reg, gl2_reg;
    logic [30:0]     tx2_reg, ty2_reg, txy2_reg;
    logic [31:0]     fmx2_reg, fmy2_reg, fmx3_reg, fmy3_reg, fmx4_reg, fmy4_reg;
    logic [31:0]     fmx5_reg, fmy5_reg, fmx6_reg, fmy6_reg;
    logic [62:0]     pxl3_reg, pyl3_reg, pcl3_reg;
    logic [46:0]     pxh3_reg, pyh3_reg, pch3_reg;
    logic [78:0]     sumx, sumy, sumc;
    logic [48:0]     mx4_reg, my4_reg, mc4_reg, mx5_reg, my5_reg, mc5_reg;
    logic [63:0]     dxl5_reg, dyl5_reg, dcl5_reg;
    logic [48:0]     dxh5_reg, dyh5_reg, dch5_reg;
    logic [80:0]     dsx, dsy, dsc;
    logic [64:0]     magx6_reg, magy6_reg, magc6_reg;
    stfs_pkg::side_t side1_reg, side2_reg, side3_reg, side4_reg, side5_reg, side6_reg;
    stfs_pkg::res_t  res_n, res7_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= {vld_reg[5:0], in_vld};
        end
    end

    // Join partial products of the wide multiplies
    assign sumx = {pxh3_reg, 32'd0} + {16'd0, pxl3_reg};
    assign sumy = {pyh3_reg, 32'd0} + {16'd0, pyl3_reg};
    assign sumc = {pch3_reg, 32'd0} + {16'd0, pcl3_reg};
    assign dsx  = {dxh5_reg, 32'd0} + {17'd0, dxl5_reg};
    assign dsy  = {dyh5_reg, 32'd0} + {17'd0, dyl5_reg};
    assign dsc  = {dch5_reg, 32'd0} + {17'd0, dcl5_reg};

    // Saturate, apply signs, clear a zero-length face
    always_comb
    begin
        res_n.stiff_xx    = stfs_pkg::sat_signed(magx6_reg, 1'b0);
        res_n.stiff_yy    = stfs_pkg::sat_signed(magy6_reg, 1'b0);
        res_n.stiff_xy    = stfs_pkg::sat_signed(magc6_reg, side6_reg.xy_neg);
        res_n.force_x     = stfs_pkg::sat_signed({33'd0, fmx6_reg}, side6_reg.fx_neg);
        res_n.force_y     = stfs_pkg::sat_signed({33'd0, fmy6_reg}, side6_reg.fy_neg);
        res_n.first_dof   = side6_reg.first_dof;
        res_n.second_dof  = side6_reg.second_dof;
        res_n.zero_length = 1'b0;
        if (side6_reg.zero)
        begin
            res_n             = '0;
            res_n.zero_length = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            // squares of the direction and the raw forces
            uu1_reg   <= u * u;
            vv1_reg   <= v * v;
            uv1_reg   <= u * v;
            fpx1_reg  <= gamma * u;
            fpy1_reg  <= gamma * v;
            gl1_reg   <= gl;
            side1_reg <= side;
            // projector terms
            tx2_reg   <= 31'h4000_0000 - uu1_reg[60:30];
            ty2_reg   <= 31'h4000_0000 - vv1_reg[60:30];
            txy2_reg  <= uv1_reg[60:30];
            fmx2_reg  <= fpx1_reg[61:30];
            fmy2_reg  <= fpy1_reg[61:30];
            gl2_reg   <= gl1_reg;
            side2_reg <= side1_reg;
            // gamma/L times projector, split in two partial products
            pxl3_reg  <= gl2_reg[31:0] * tx2_reg;
            pxh3_reg  <= gl2_reg[47:32] * tx2_reg;
            pyl3_reg  <= gl2_reg[31:0] * ty2_reg;
            pyh3_reg  <= gl2_reg[47:32] * ty2_reg;
            pcl3_reg  <= gl2_reg[31:0] * txy2_reg;
            pch3_reg  <= gl2_reg[47:32] * txy2_reg;
            fmx3_reg  <= fmx2_reg;
            fmy3_reg  <= fmy2_reg;
            side3_reg <= side2_reg;
            mx4_reg   <= sumx[78:30];
            my4_reg   <= sumy[78:30];
            mc4_reg   <= sumc[78:30];
            fmx4_reg  <= fmx3_reg;
            fmy4_reg  <= fmy3_reg;
            side4_reg <= side3_reg;
            // dynamic scale, split in two partial products
            dxl5_reg  <= mx4_reg[31:0] * stiffness_scale;
            dxh5_reg  <= mx4_reg[48:32] * stiffness_scale;
            dyl5_reg  <= my4_reg[31:0] * stiffness_scale;
            dyh5_reg  <= my4_reg[48:32] * stiffness_scale;
            dcl5_reg  <= mc4_reg[31:0] * stiffness_scale;
            dch5_reg  <= mc4_reg[48:32] * stiffness_scale;
            mx5_reg   <= mx4_reg;
            my5_reg   <= my4_reg;
            mc5_reg   <= mc4_reg;
            fmx5_reg  <= fmx4_reg;
            fmy5_reg  <= fmy4_reg;
            side5_reg <= side4_reg;
            magx6_reg <= dynamic_mode ? dsx[80:16] : {16'd0, mx5_reg};
            magy6_reg <= dynamic_mode ? dsy[80:16] : {16'd0, my5_reg};
            magc6_reg <= dynamic_mode ? dsc[80:16] : {16'd0, mc5_reg};
            fmx6_reg  <= fmx5_reg;
            fmy6_reg  <= fmy5_reg;
            side6_reg <= side5_reg;
            res7_reg  <= res_n;
        end
    end

    assign out_vld = vld_reg[6];
    assign res     = res7_reg;

endmodule

// ===== rtl/core/stfs_checker.sv =====
`timescale 1ns / 1ps
`include "surface_tension_face_stiffness_assert.svh"
module stfs_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_ready,
    input logic               out_valid,
    input logic               out_ready,
    input logic signed [31:0] stiff_xx,
    input logic signed [31:0] stiff_xy,
    input logic signed [31:0] stiff_yy,
    input logic signed [31:0] force_x,
    input logic signed [31:0] force_y,
    input logic [2:0]         first_dof,
    input logic [2:0]         second_dof,
    input logic               zero_length,
    input logic               cfg_valid,
    input logic               cfg_ready,
    input logic [2:0]         cfg_index
);

    // A stalled item stays valid and keeps its stiff_xy and force_x values
    `STFS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(stiff_xy) && $stable(force_x), "output item changed while stalled")

    // A zero-length face carries only the flag
    `STFS_ASSERT_SAME(a_zero_clear, out_valid && zero_length, stiff_xx == 0 && stiff_xy == 0 && stiff_yy == 0 && force_x == 0 && force_y == 0 && first_dof == 0 && second_dof == 0, "zero-length face has nonzero fields")

    // Diagonal stiffness never goes negative, DOF indices are even
    `STFS_ASSERT_SAME(a_diag_dof, out_valid, !stiff_xx[31] && !stiff_yy[31] && !first_dof[0] && !second_dof[0], "negative diagonal or odd DOF index")

    // A write that changes the ramp blocks input while the tension is recomputed
    `STFS_ASSERT_NEXT(a_ramp_block, cfg_valid && cfg_ready && (cfg_index == stfs_pkg::CFG_SURFACE_TENSION || cfg_index == stfs_pkg::CFG_RAMP_TIME || cfg_index == stfs_pkg::CFG_CURRENT_TIME), !in_ready, "input taken during ramp update")

endmodule

bind surface_tension_face_stiffness stfs_checker u_stfs_checker (.*);
